FILE: rtl/ted_pkg.sv
package ted_pkg;

  // Register map of the configuration port
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 9;

  // Reset values and limits of the frame geometry
  localparam logic [7:0] THRESHOLD_RESET = 8'd127;
  localparam logic [8:0] SIZE_RESET      = 9'd256;
  localparam int unsigned SIZE_MIN       = 3;

  // Item kinds on the input channel
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_PAD   = 1'b1;

  // Output pixel codes
  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  // One window column: bit 2 row above, bit 1 middle row, bit 0 row below
  typedef logic [2:0] col_t;
  localparam col_t WHITE_COL = 3'b111;

  // Control of one window cell
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/ted_cell.sv
module ted_cell (
  input  logic                clk,
  input  logic                rst,
  input  ted_pkg::cell_ctrl_t ctrl,
  input  ted_pkg::col_t       d,
  output ted_pkg::col_t       q
);
  import ted_pkg::*;

  col_t col;

  // Shift in the neighbor's column, or load white at a row start
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= WHITE_COL;
    end else if (ctrl.advance) begin
      col <= ctrl.clear ? WHITE_COL : d;
    end
  end

  assign q = col;

endmodule

FILE: rtl/ted_line_store.sv
module ted_line_store #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [1:0]               rdata
);
  import ted_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_raw;
  logic [1:0]    byp_data;
  logic          byp;
  logic          in_fill;
  logic [FW-1:0] fill;

  // Write one entry, read one entry ahead, registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw   <= mem[raddr];
    byp_data <= wdata;
  end

  // Columns are written in order from zero, so a fill mark tells written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      byp     <= 1'b0;
      in_fill <= 1'b0;
    end else begin
      if (we && FW'(waddr) == fill) begin
        fill <= fill + FW'(1);
      end
      byp     <= we && (waddr == raddr);
      in_fill <= FW'(raddr) < fill;
    end
  end

  // Entries never written read as white
  always_comb begin
    if (byp) begin
      rdata = byp_data;
    end else if (in_fill) begin
      rdata = rd_raw;
    end else begin
      rdata = 2'b11;
    end
  end

endmodule

FILE: rtl/threshold_edge_detect_3x3.sv
// Binarizes a grayscale raster against the threshold register (strictly above
// is white) and keeps only black pixels on a boundary: a black pixel with all
// eight neighbors black turns white, and neighbors outside the image count as
// white. One pixel is taken per clock; the result for a pixel is formed when
// the beat one row and one pixel later is taken and leaves from the output
// register the cycle after, so the clamped width + 1 padding beats flush the
// last row, and frame_last marks the final pixel. The line store is read one
// address ahead of the next pixel, so the input is not ready in the cycle
// after reset and in the cycle after every configuration write; the input
// also stalls while a result waits in the output register with out_ready low.
// Otherwise the rate is one beat per clock, set by the registered line store
// read and the two-cell window shift. Write configuration only while the block
// is idle.
module threshold_edge_detect_3x3 #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ted_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [ted_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      pixel_out,
  output logic                            frame_last
);
  import ted_pkg::*;

  localparam int WLIM = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam int HLIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int CW   = $clog2(WLIM + 1);
  localparam int AW   = $clog2(WLIM);
  localparam int RW   = $clog2(HLIM + 3);

  logic [7:0]    threshold;
  logic [8:0]    width_in_use;
  logic [8:0]    height_in_use;
  logic          hold;

  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt_next;
  logic [RW-1:0] row_cnt_next;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] cn;
  logic [RW-1:0] rn;
  logic [CW-1:0] cn_ahead;
  logic [RW-1:0] rn_ahead;
  logic [CW-1:0] c_inc;

  logic          accept;
  logic          bot;
  logic          top;
  logic          mid;
  logic          restart;
  logic          emit;
  logic          last;
  logic [1:0]    ls_rdata;
  col_t          col;
  col_t          cell_a;
  col_t          cell_b;
  col_t          newest;
  cell_ctrl_t    ctrl_a;
  cell_ctrl_t    ctrl_b;
  logic [8:0]    win;
  logic          pix_white;

  // Fold a position into the current geometry: wrap a column past the width,
  // pin rows at or past the flush row to its start
  function automatic logic [RW+CW-1:0] norm_pos(
    input logic [CW-1:0] c,
    input logic [RW-1:0] r,
    input logic [CW-1:0] w,
    input logic [RW-1:0] h
  );
    logic [CW-1:0] c1;
    logic [RW-1:0] r1;
    c1 = c;
    r1 = r;
    if (c >= w) begin
      c1 = '0;
      r1 = r + RW'(1);
    end
    if (r1 >= h + RW'(1)) begin
      r1 = h + RW'(1);
      c1 = '0;
    end
    return {r1, c1};
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RESET;
      width_in_use  <= SIZE_RESET;
      height_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold     <= cfg_data[7:0];
        REG_WIDTH:     width_in_use  <= cfg_data[8:0];
        REG_HEIGHT:    height_in_use <= cfg_data[8:0];
        default:       ;
      endcase
    end
  end

  // Clamp the frame geometry
  always_comb begin
    if (width_in_use < 9'(SIZE_MIN)) begin
      w_eff = CW'(SIZE_MIN);
    end else if (int'(width_in_use) > WLIM) begin
      w_eff = CW'(WLIM);
    end else begin
      w_eff = CW'(width_in_use);
    end
    if (height_in_use < 9'(SIZE_MIN)) begin
      h_eff = RW'(SIZE_MIN);
    end else if (int'(height_in_use) > HLIM) begin
      h_eff = RW'(HLIM);
    end else begin
      h_eff = RW'(height_in_use);
    end
  end

  // Stall after reset or a register write so the read-ahead refreshes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b1;
    end else begin
      hold <= cfg_we;
    end
  end

  assign in_ready = !hold && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Position of this beat and the column it forms
  assign {rn, cn} = norm_pos(col_cnt, row_cnt, w_eff, h_eff);
  assign bot      = (rn >= h_eff || req_type == REQ_PAD) ? 1'b1 : (pixel_in > threshold);
  assign top      = (rn == '0) ? 1'b1 : ls_rdata[1];
  assign mid      = (rn == '0) ? 1'b1 : ls_rdata[0];
  assign col      = {top, mid, bot};
  assign restart  = (cn == '0);
  assign last     = (rn == h_eff + RW'(1));
  assign emit     = restart ? (rn >= RW'(2)) : (rn >= RW'(1));
  assign c_inc    = cn + CW'(1);

  // Advance the raster position
  always_comb begin
    col_cnt_next = col_cnt;
    row_cnt_next = row_cnt;
    if (accept) begin
      if (last) begin
        col_cnt_next = '0;
        row_cnt_next = '0;
      end else if (c_inc >= w_eff) begin
        col_cnt_next = '0;
        row_cnt_next = rn + RW'(1);
      end else begin
        col_cnt_next = c_inc;
        row_cnt_next = rn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // Line store address of the next beat
  assign {rn_ahead, cn_ahead} = norm_pos(col_cnt_next, row_cnt_next, w_eff, h_eff);

  ted_line_store #(
    .DEPTH (WLIM)
  ) u_line_store (
    .clk   (clk),
    .rst   (rst),
    .we    (accept),
    .waddr (cn[AW-1:0]),
    .wdata ({mid, bot}),
    .raddr (cn_ahead[AW-1:0]),
    .rdata (ls_rdata)
  );

  // Window: cell_b holds the center column, cell_a the one left of it
  assign ctrl_a = '{advance: accept, clear: restart};
  assign ctrl_b = '{advance: accept, clear: 1'b0};

  ted_cell u_cell_a (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_a),
    .d    (cell_b),
    .q    (cell_a)
  );

  ted_cell u_cell_b (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_b),
    .d    (col),
    .q    (cell_b)
  );

  // Right neighbor column is white past the row end
  assign newest    = restart ? WHITE_COL : col;
  assign win       = {newest, cell_b, cell_a};
  assign pix_white = cell_b[1] || (win == '0);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      pixel_out  <= pix_white ? PIX_WHITE : PIX_BLACK;
      frame_last <= last;
    end
  end

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken right after a register write");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (col_cnt == '0 && row_cnt == '0))
    else $error("position not cleared after the final pixel");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    int'(row_cnt) <= HLIM + 1)
    else $error("row count beyond the flush row");

  a_ahead_bound: assert property (@(posedge clk) disable iff (rst)
    rn_ahead <= h_eff + RW'(1))
    else $error("read-ahead row beyond the flush row");

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ted_pkg::*;

  localparam int unsigned MAX_W          = 256;
  localparam int unsigned MAX_H          = 256;
  localparam int unsigned TOTAL_ITEMS    = 1350;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Predicts the boundary image beat by beat and holds the beats still due
  class boundary_tracker;
    typedef struct packed {
      logic [7:0] pix;
      logic       last;
    } out_beat_t;

    out_beat_t   due_q[$];
    int unsigned max_w;
    int unsigned max_h;
    logic [7:0]  thr;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    bit          above_row[];
    bit          mid_row[];
    logic [8:0]  win;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int          mismatches;

    function new(int unsigned mw, int unsigned mh);
      max_w = mw;
      max_h = mh;
      above_row = new[mw];
      mid_row = new[mw];
      mismatches = 0;
      thr = THRESHOLD_RESET;
      width_reg = SIZE_RESET;
      height_reg = SIZE_RESET;
      foreach (above_row[i]) above_row[i] = 1'b1;
      foreach (mid_row[i]) mid_row[i] = 1'b1;
      win = '1;
      col_cnt = 0;
      row_cnt = 0;
    endfunction

    function int unsigned clamp(logic [8:0] v, int unsigned maxv);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function int unsigned cur_width();
      return clamp(width_reg, max_w);
    endfunction

    function int unsigned cur_height();
      return clamp(height_reg, max_h);
    endfunction

    function void write_reg(reg_index_t idx, logic [8:0] val);
      case (idx)
        REG_THRESHOLD: thr = val[7:0];
        REG_WIDTH:     width_reg = val;
        REG_HEIGHT:    height_reg = val;
        default: ;
      endcase
    endfunction

    function bit at_frame_start();
      return (col_cnt == 0) && (row_cnt == 0);
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction

    // Advance the window by one accepted input beat
    function void take_pixel(logic req, logic [7:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit          top;
      bit          midb;
      bit          bot;
      logic [8:0]  emit_win;
      bit          emit;
      bit          last;
      out_beat_t   beat;
      w = cur_width();
      h = cur_height();
      c = col_cnt;
      r = row_cnt;
      last = 1'b0;

      // Wrap to the next row, and pin anything past the flush row to it
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r > h + 1) begin
        r = h + 1;
        c = 0;
      end
      if (r == h + 1) c = 0;

      // Rows below the image and padding read as white
      if (r >= h || req == REQ_PAD) bot = 1'b1;
      else bot = (pix > thr);

      // First row never sees the line stores of the previous frame
      top = (r == 0) ? 1'b1 : above_row[c];
      midb = (r == 0) ? 1'b1 : mid_row[c];
      above_row[c] = midb;
      mid_row[c] = bot;

      if (c == 0) begin
        emit_win = {3'b111, win[8:3]};
        win = {top, midb, bot, 6'h3F};
        emit = (r >= 2);
        last = (r == h + 1);
      end else begin
        win = {top, midb, bot, win[8:3]};
        emit_win = win;
        emit = (r >= 1);
      end

      if (last) begin
        col_cnt = 0;
        row_cnt = 0;
      end else begin
        c++;
        if (c >= w) begin
          c = 0;
          r++;
        end
        col_cnt = c;
        row_cnt = r;
      end

      if (emit) begin
        beat.pix = (emit_win[4] || emit_win == 9'd0) ? PIX_WHITE : PIX_BLACK;
        beat.last = last;
        due_q.push_back(beat);
      end
    endfunction

    // Compare one output beat with the oldest one due
    function void match_output(logic [7:0] pix, logic last);
      out_beat_t exp_beat;
      if (due_q.size() == 0) begin
        $error("output beat with nothing due: pixel_out=%0d frame_last=%0b", pix, last);
        mismatches++;
        return;
      end
      exp_beat = due_q.pop_front();
      if (pix !== exp_beat.pix) begin
        $error("pixel_out: expected %0d, actual %0d", exp_beat.pix, pix);
        mismatches++;
      end
      if (last !== exp_beat.last) begin
        $error("frame_last: expected %0b, actual %0b", exp_beat.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       req_type = REQ_PIXEL;
  logic [7:0] pixel_in = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] pixel_out;
  logic       frame_last;

  boundary_tracker tracker;
  int unsigned     sent_total = 0;
  int unsigned     burst_left = 0;
  int unsigned     idle_cycles = 0;

  threshold_edge_detect_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_last(frame_last)
  );

  always #6 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.take_pixel(req_type, pixel_in);
      if (out_valid && out_ready) tracker.match_output(pixel_out, frame_last);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the output on a changing pattern
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    int unsigned period;
    int unsigned stall_left;
    logic        nxt;
    tick = 0;
    stall_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 300);
      period = $urandom_range(2, 7);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: nxt = 1'b1;
          1: nxt = 1'($urandom_range(0, 1));
          2: nxt = (tick % period) != 0;
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              nxt = 1'b0;
            end else if ($urandom_range(0, 20) == 0) begin
              stall_left = $urandom_range(5, 30);
              nxt = 1'b0;
            end else begin
              nxt = 1'b1;
            end
          end
        endcase
        out_ready <= nxt;
      end
    end
  end

  // Send one beat in bursts with gaps; call and return at a falling edge
  task automatic send_item(logic r, logic [7:0] p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= r;
    pixel_in <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  // Drop valid, drain all due beats, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(bit set_th, logic [8:0] th, bit set_w, logic [8:0] w,
                              bit set_h, logic [8:0] h);
    if (set_th) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_THRESHOLD;
      cfg_data <= th;
      tracker.write_reg(REG_THRESHOLD, th);
      @(negedge clk);
    end
    if (set_w) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_WIDTH;
      cfg_data <= w;
      tracker.write_reg(REG_WIDTH, w);
      @(negedge clk);
    end
    if (set_h) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_HEIGHT;
      cfg_data <= h;
      tracker.write_reg(REG_HEIGHT, h);
      @(negedge clk);
    end
    if (set_th || set_w || set_h) cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] gen_pixel(int white_pct);
    int unsigned thr;
    thr = 32'(tracker.thr);
    if (white_pct < 0 || thr == 255) return 8'($urandom_range(0, 255));
    if (int'($urandom_range(0, 99)) < white_pct) return 8'($urandom_range(thr + 1, 255));
    return 8'($urandom_range(0, thr));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 5))
      0: return 5;
      1: return 30;
      2: return 50;
      3: return 70;
      4: return 95;
      default: return -1;
    endcase
  endfunction

  function automatic logic [8:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd255;
      2: return 9'h1FF;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [8:0] pick_size(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0: return 9'($urandom_range(0, 2));
      1: return 9'($urandom_range(hi + 1, hi + 4));
      default: return 9'($urandom_range(lo, hi));
    endcase
  endfunction

  // One frame in raster order, then width + 1 flush beats
  task automatic send_frame(int white_pct);
    int unsigned w;
    int unsigned h;
    w = tracker.cur_width();
    h = tracker.cur_height();
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 49) == 0) send_item(REQ_PAD, 8'($urandom_range(0, 255)));
      else send_item(REQ_PIXEL, gen_pixel(white_pct));
    end
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
      else send_item(REQ_PAD, 8'($urandom_range(0, 255)));
    end
  endtask

  // Pad out whatever frame is in progress
  task automatic finish_frame();
    while (!tracker.at_frame_start()) send_item(REQ_PAD, 8'($urandom_range(0, 255)));
  endtask

  task automatic pick_settings(bit all_regs, bit need_sizes);
    program_regs(all_regs || $urandom_range(0, 1), pick_threshold(),
                 all_regs || need_sizes || $urandom_range(0, 1), pick_size(3, 8),
                 all_regs || need_sizes || $urandom_range(0, 1), pick_size(3, 6));
  endtask

  initial begin
    int unsigned n;
    bit          big_done;
    bit          need_sizes;
    bit          first_phase;
    big_done = 1'b0;
    need_sizes = 1'b0;
    first_phase = 1'b1;
    tracker = new(MAX_W, MAX_H);

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    // Directed: 3x3 frame via clamped sizes, threshold with bit 8 set
    program_regs(1'b1, 9'h17F, 1'b1, 9'd0, 1'b1, 9'd2);

    // All black frame: border stays black, the enclosed center turns white
    for (int i = 0; i < 9; i++) send_item(REQ_PIXEL, (i % 2) ? 8'd127 : 8'd0);
    send_item(REQ_PAD, 8'd0);
    send_item(REQ_PAD, 8'd255);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PAD, 8'd0);

    // Values around the threshold, padding inside the image
    send_item(REQ_PIXEL, 8'd255);
    send_item(REQ_PIXEL, 8'd128);
    send_item(REQ_PIXEL, 8'd127);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PAD, 8'd0);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PIXEL, 8'd127);
    send_item(REQ_PIXEL, 8'd0);
    send_item(REQ_PIXEL, 8'd255);
    repeat (4) send_item(REQ_PAD, 8'd255);

    // Random phases, mostly whole frames, some noise cut off mid-frame,
    // and one large frame that is either full width or full height
    while (sent_total < TOTAL_ITEMS || !big_done) begin
      if (!big_done && sent_total >= TOTAL_ITEMS / 4) begin
        finish_frame();
        settle();
        if ($urandom_range(0, 1) == 0) begin
          program_regs(1'b1, pick_threshold(),
                       1'b1, $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)),
                       1'b1, 9'($urandom_range(0, 3)));
        end else begin
          program_regs(1'b1, pick_threshold(), 1'b1, 9'($urandom_range(0, 3)),
                       1'b1, $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)));
        end
        send_frame(pick_pct());
        big_done = 1'b1;
        need_sizes = 1'b1;
      end else begin
        settle();
        pick_settings(first_phase, need_sizes);
        first_phase = 1'b0;
        need_sizes = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 3 * tracker.cur_width());
          repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end else begin
          finish_frame();
          repeat ($urandom_range(1, 3)) send_frame(pick_pct());
        end
      end
    end

    // Drain and report
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
